// ----- hdl/rc5_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rc5_pkg;
  localparam logic [31:0] MAGIC_P = 32'hB7E15163;
  localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

  typedef enum logic [2:0] {
    KIND_SETUP   = 3'd0,
    KIND_BYTE    = 3'd1,
    KIND_FINISH  = 3'd2,
    KIND_ENCRYPT = 3'd3,
    KIND_DECRYPT = 3'd4
  } kind_t;

  localparam logic [2:0] REG_KEY_LOW    = 3'd0;
  localparam logic [2:0] REG_KEY_HIGH   = 3'd1;
  localparam logic [2:0] REG_KEY_LENGTH = 3'd2;
  localparam logic [2:0] REG_ROUNDS     = 3'd3;
  localparam logic [2:0] REG_PAD_ENABLE = 3'd4;
  localparam logic [2:0] REG_INIT_VEC   = 3'd5;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_SETUP_LOAD,   // load key words, chain, clear buffer, counters
    OP_TABLE_FILL,   // write S[i] = P + i*Q
    OP_MIX_A,        // key schedule: compute and write A into S[i]
    OP_MIX_B,        // key schedule: compute B into L[j]
    OP_BYTE,         // insert a byte into the buffer
    OP_PAD,          // pad the buffer
    OP_ENC_START,    // load A,B from the chosen source
    OP_ENC_A,        // half round A
    OP_ENC_B,        // half round B
    OP_DEC_B,
    OP_DEC_A,
    OP_DEC_END,      // final subtraction on A
    OP_CHAIN_DONE,   // commit chain block, reset buffer
    OP_RESTART,
    OP_READ,         // issue expanded key read only
    OP_ADD_A,        // whitening: A += S[0]
    OP_ADD_B,        // whitening: B += S[1]
    OP_SUB_B         // final subtraction on B
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       use_chain;   // encrypt source: buffer xor chain
    logic [8:0] addr;        // expanded key address for read or write
    logic [1:0] lidx;        // key word index
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] fill;
    logic [2:0] lwords;      // number of key words, 1..4
    logic       buf_full;
  } dp_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] c);
    logic [63:0] d;
    d = {x, x} << c;
    return d[63:32];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] c);
    logic [63:0] d;
    d = {x, x} >> c;
    return d[31:0];
  endfunction
endpackage
`default_nettype wire

// ----- hdl/rc5_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface rc5_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_in;
  logic [63:0] block_in;
  modport source (output valid, kind, data_in, block_in, input ready);
  modport sink (input valid, kind, data_in, block_in, output ready);
endinterface

interface rc5_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [63:0] block_out;
  logic        status;
  logic        last;
  modport source (output valid, byte_out, block_out, status, last, input ready);
  modport sink (input valid, byte_out, block_out, status, last, output ready);
endinterface

interface rc5_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/rc5_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rc5_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rc5_pkg::dp_cmd_t cmd,
  input  wire logic [7:0]       data_byte,
  input  wire logic [63:0]      block_in,
  input  wire logic [63:0]      key_low,
  input  wire logic [63:0]      key_high,
  input  wire logic [4:0]       key_bytes,
  input  wire logic [63:0]      init_vector,
  output rc5_pkg::dp_stat_t     stat,
  output logic [63:0]           result
);
  logic [31:0] skey [0:511];
  logic [31:0] rd;
  logic [31:0] lw [0:3];
  logic [31:0] wa, wb;
  logic [31:0] fill_val;
  logic [63:0] buffer, chain;
  logic [3:0]  fill;
  logic [2:0]  lwords;
  logic [31:0] mix_a;
  logic [31:0] mix_b;
  logic [31:0] new_a, new_b;
  logic [127:0] key_all;
  logic [63:0] pad_buf;

  assign key_all = {key_high, key_low};
  assign mix_a = rc5_pkg::rotl(rd + wa + wb, 5'd3);
  assign mix_b = rc5_pkg::rotl(lw[cmd.lidx] + wa + wb, wa[4:0] + wb[4:0]);
  assign new_a = rc5_pkg::rotl(wa ^ wb, wb[4:0]) + rd;
  assign new_b = rc5_pkg::rotl(wb ^ wa, wa[4:0]) + rd;

  always_comb begin
    pad_buf = buffer;
    for (int p = 0; p < 8; p++) begin
      if (4'(p) >= fill) begin
        pad_buf[8*p +: 8] = 8'(4'd8 - fill);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd <= skey[cmd.addr];
    case (cmd.op)
      rc5_pkg::OP_TABLE_FILL: skey[cmd.addr] <= fill_val;
      rc5_pkg::OP_MIX_A:      skey[cmd.addr] <= mix_a;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer <= '0;
      chain  <= '0;
      fill   <= '0;
    end else begin
      case (cmd.op)
        rc5_pkg::OP_SETUP_LOAD, rc5_pkg::OP_RESTART: begin
          chain  <= init_vector;
          buffer <= '0;
          fill   <= '0;
        end
        rc5_pkg::OP_BYTE: begin
          buffer[8*fill[2:0] +: 8] <= data_byte;
          fill <= fill + 4'd1;
        end
        rc5_pkg::OP_PAD: buffer <= pad_buf;
        rc5_pkg::OP_CHAIN_DONE: begin
          chain  <= {wb, wa};
          buffer <= '0;
          fill   <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      rc5_pkg::OP_SETUP_LOAD: begin
        for (int w = 0; w < 4; w++) begin
          for (int b = 0; b < 4; b++) begin
            if (5'(4*w + b) < key_bytes) begin
              lw[w][8*b +: 8] <= key_all[32*w + 8*b +: 8];
            end else begin
              lw[w][8*b +: 8] <= 8'd0;
            end
          end
        end
        lwords   <= 3'((key_bytes + 5'd3) >> 2);
        fill_val <= rc5_pkg::MAGIC_P;
        wa <= '0;
        wb <= '0;
      end
      rc5_pkg::OP_TABLE_FILL: fill_val <= fill_val + rc5_pkg::MAGIC_Q;
      rc5_pkg::OP_MIX_A: wa <= mix_a;
      rc5_pkg::OP_MIX_B: begin
        wb <= mix_b;
        lw[cmd.lidx] <= mix_b;
      end
      rc5_pkg::OP_ENC_START: begin
        if (cmd.use_chain) begin
          wa <= buffer[31:0] ^ chain[31:0];
          wb <= buffer[63:32] ^ chain[63:32];
        end else begin
          wa <= block_in[31:0];
          wb <= block_in[63:32];
        end
      end
      rc5_pkg::OP_ADD_A: wa <= wa + rd;
      rc5_pkg::OP_ADD_B: wb <= wb + rd;
      rc5_pkg::OP_ENC_A: wa <= new_a;
      rc5_pkg::OP_ENC_B: wb <= new_b;
      rc5_pkg::OP_DEC_B: wb <= rc5_pkg::rotr(wb - rd, wa[4:0]) ^ wa;
      rc5_pkg::OP_DEC_A: wa <= rc5_pkg::rotr(wa - rd, wb[4:0]) ^ wb;
      rc5_pkg::OP_SUB_B: wb <= wb - rd;
      rc5_pkg::OP_DEC_END: wa <= wa - rd;
      default: ;
    endcase
  end

  assign stat.fill     = fill;
  assign stat.lwords   = lwords;
  assign stat.buf_full = (fill == 4'd8);
  assign result        = {wb, wa};
endmodule
`default_nettype wire

// ----- hdl/rc5_control.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rc5_control #(
  parameter int MAX_ROUNDS = 255
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [2:0]        in_kind,
  output logic                   in_ready,
  input  wire logic [7:0]        rounds,
  input  wire logic              pad_enable,
  input  wire rc5_pkg::dp_stat_t stat,
  input  wire logic [63:0]       result,
  output rc5_pkg::dp_cmd_t       cmd,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             byte_out,
  output logic [63:0]            block_out,
  output logic                   status,
  output logic                   last
);
  localparam logic [7:0] RMAX = 8'(MAX_ROUNDS);

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_MIX_A, S_MIX_B, S_ENC_LOAD, S_ENC_WB, S_ENC_A, S_ENC_B,
    S_DEC_B, S_DEC_A, S_DEC_END1, S_DEC_END2, S_RESULT, S_OUT_BYTES, S_OUT_ONE,
    S_BYTE_CHK
  } state_t;

  state_t      state;
  logic [7:0]  r_eff;
  logic [9:0]  tcount;      // 2*(r+1)
  logic [8:0]  i_idx;
  logic [1:0]  j_idx;
  logic [10:0] steps;
  logic [10:0] n_steps;
  logic [7:0]  rnd;
  logic        chain_mode;
  logic        restart_after;
  logic [2:0]  bcount;
  logic [63:0] res_q;
  logic [8:0]  i_next;
  logic [1:0]  j_next;
  logic [9:0]  big;

  assign r_eff  = (rounds > RMAX) ? RMAX : rounds;
  assign tcount = {1'b0, r_eff, 1'b0} + 10'd2;
  assign i_next = ({1'b0, i_idx} + 10'd1 == tcount) ? 9'd0 : i_idx + 9'd1;
  assign j_next = ({1'b0, j_idx} + 3'd1 == stat.lwords) ? 2'd0 : j_idx + 2'd1;
  assign big    = (tcount > {7'd0, stat.lwords}) ? tcount : {7'd0, stat.lwords};
  assign n_steps = 11'({big, 1'b0} + {1'b0, big});

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign byte_out = (state == S_OUT_BYTES) ? res_q[8*bcount +: 8] : 8'd0;

  always_comb begin
    cmd.op        = rc5_pkg::OP_NONE;
    cmd.use_chain = chain_mode;
    cmd.addr      = i_idx;
    cmd.lidx      = j_idx;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_kind)
            rc5_pkg::KIND_SETUP:  cmd.op = rc5_pkg::OP_SETUP_LOAD;
            rc5_pkg::KIND_BYTE:   cmd.op = rc5_pkg::OP_BYTE;
            rc5_pkg::KIND_FINISH: cmd.op = pad_enable ? rc5_pkg::OP_PAD
                                                      : rc5_pkg::OP_RESTART;
            rc5_pkg::KIND_ENCRYPT: begin
              cmd.op = rc5_pkg::OP_ENC_START;
              cmd.use_chain = 1'b0;
              cmd.addr = 9'd0;
            end
            rc5_pkg::KIND_DECRYPT: begin
              cmd.op = rc5_pkg::OP_ENC_START;
              cmd.use_chain = 1'b0;
              cmd.addr = {r_eff, 1'b1};
            end
            default: ;
          endcase
        end
      end
      S_FILL:  cmd.op = rc5_pkg::OP_TABLE_FILL;
      S_MIX_A: cmd.op = (steps == 11'd0) ? rc5_pkg::OP_READ : rc5_pkg::OP_MIX_A;
      S_MIX_B: begin
        cmd.op = rc5_pkg::OP_MIX_B;
        cmd.addr = i_next;
      end
      S_BYTE_CHK: begin
        cmd.op = rc5_pkg::OP_ENC_START;
        cmd.use_chain = 1'b1;
        cmd.addr = 9'd0;
      end
      S_ENC_LOAD: begin
        // Whitening: A += S[0] this cycle, read S[1].
        cmd.op = rc5_pkg::OP_ADD_A;
        cmd.addr = 9'd1;
      end
      S_ENC_WB: begin
        // Whitening: B += S[1] this cycle, read S[2] for the first round.
        cmd.op = rc5_pkg::OP_ADD_B;
        cmd.addr = 9'd2;
      end
      S_ENC_A: begin
        cmd.op = rc5_pkg::OP_ENC_A;
        cmd.addr = {rnd, 1'b0} + 9'd3;
      end
      S_ENC_B: begin
        cmd.op = rc5_pkg::OP_ENC_B;
        cmd.addr = {rnd, 1'b0} + 9'd2;
      end
      S_DEC_B: begin
        cmd.op = rc5_pkg::OP_DEC_B;
        cmd.addr = {rnd, 1'b0};
      end
      S_DEC_A: begin
        cmd.op = rc5_pkg::OP_DEC_A;
        cmd.addr = {rnd, 1'b0} - 9'd1;
      end
      S_DEC_END1: begin
        cmd.op = rc5_pkg::OP_SUB_B;
        cmd.addr = 9'd0;
      end
      S_DEC_END2: cmd.op = rc5_pkg::OP_DEC_END;
      S_RESULT: begin
        if (chain_mode) cmd.op = rc5_pkg::OP_CHAIN_DONE;
      end
      S_OUT_BYTES: begin
        if (out_ready && bcount == 3'd7 && restart_after)
          cmd.op = rc5_pkg::OP_RESTART;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      i_idx <= '0;
      j_idx <= '0;
      steps <= '0;
      rnd <= '0;
      chain_mode <= 1'b0;
      restart_after <= 1'b0;
      bcount <= '0;
      status <= 1'b0;
      last <= 1'b0;
      block_out <= '0;
      res_q <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            case (in_kind)
              rc5_pkg::KIND_SETUP: begin
                i_idx <= '0;
                state <= S_FILL;
              end
              rc5_pkg::KIND_BYTE: begin
                if (stat.fill[2:0] == 3'd7) state <= S_BYTE_CHK;
              end
              rc5_pkg::KIND_FINISH: begin
                if (pad_enable) begin
                  restart_after <= 1'b1;
                  state <= S_BYTE_CHK;
                end else begin
                  block_out <= '0;
                  status <= (stat.fill != 4'd0);
                  last <= 1'b1;
                  out_valid <= 1'b1;
                  state <= S_OUT_ONE;
                end
              end
              rc5_pkg::KIND_ENCRYPT: begin
                chain_mode <= 1'b0;
                rnd <= 8'd0;
                state <= S_ENC_LOAD;
              end
              rc5_pkg::KIND_DECRYPT: begin
                chain_mode <= 1'b0;
                rnd <= r_eff;
                state <= (r_eff == 8'd0) ? S_DEC_END1 : S_DEC_B;
              end
              default: ;
            endcase
          end
        end
        S_FILL: begin
          i_idx <= i_next;
          if (i_next == 9'd0) begin
            j_idx <= '0;
            steps <= '0;
            state <= S_MIX_A;
          end
        end
        S_MIX_A: begin
          // First visit only primes the read of S[0].
          if (steps == 11'd0) steps <= 11'd1;
          else state <= S_MIX_B;
        end
        S_MIX_B: begin
          i_idx <= i_next;
          j_idx <= j_next;
          if (steps == n_steps) begin
            state <= S_IDLE;
          end else begin
            steps <= steps + 11'd1;
            state <= S_MIX_A;
          end
        end
        S_BYTE_CHK: begin
          chain_mode <= 1'b1;
          rnd <= 8'd0;
          state <= S_ENC_LOAD;
        end
        S_ENC_LOAD: state <= S_ENC_WB;
        S_ENC_WB: state <= (r_eff == 8'd0) ? S_RESULT : S_ENC_A;
        S_ENC_A: begin
          rnd <= rnd + 8'd1;
          state <= S_ENC_B;
        end
        S_ENC_B: state <= (rnd == r_eff) ? S_RESULT : S_ENC_A;
        S_DEC_B: state <= S_DEC_A;
        S_DEC_A: begin
          rnd <= rnd - 8'd1;
          state <= (rnd == 8'd1) ? S_DEC_END1 : S_DEC_B;
        end
        S_DEC_END1: state <= S_DEC_END2;
        S_DEC_END2: state <= S_RESULT;
        S_RESULT: begin
          if (chain_mode) begin
            res_q <= result;
            bcount <= '0;
            block_out <= '0;
            status <= 1'b0;
            last <= 1'b0;
            out_valid <= 1'b1;
            state <= S_OUT_BYTES;
          end else begin
            block_out <= result;
            status <= 1'b0;
            last <= 1'b1;
            out_valid <= 1'b1;
            state <= S_OUT_ONE;
          end
        end
        S_OUT_BYTES: begin
          if (out_ready) begin
            bcount <= bcount + 3'd1;
            last <= (bcount == 3'd6);
            if (bcount == 3'd7) begin
              out_valid <= 1'b0;
              restart_after <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        S_OUT_ONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_valid_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT_BYTES || state == S_OUT_ONE))
    else $error("result shown outside output state");
  a_last_bytes: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT_BYTES && out_valid) |-> (last == (bcount == 3'd7)))
    else $error("last mismatched on ciphertext bytes");
endmodule
`default_nettype wire

// ----- hdl/rc5_cbc_cipher_engine_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// RC5-32 block cipher engine with CBC chaining and byte-count padding. A key setup
// item expands the configured key with the standard schedule: a table fill, a
// priming read of the table, then 3*max(2*(rounds+1), key words) schedule steps in
// all. A plaintext byte that completes a block starts its CBC encryption. A direct
// encrypt or decrypt runs one half-round a cycle from a single-port expanded key
// memory, with the whitening additions or final subtractions as separate steps, and
// a completed or padded CBC block first passes a state that loads the buffer xor
// chain. Eight ciphertext bytes then leave one transfer at a time, as the output
// accepts them. A new item is taken only in the idle state, once any result of the
// previous one has been transferred.
module rc5_cbc_cipher_engine_unit #(
  parameter int MAX_ROUNDS    = 255,
  parameter int MAX_KEY_BYTES = 16
) (
  input wire logic clk,
  input wire logic rst,
  rc5_in_if.sink   in_ch,
  rc5_out_if.source out_ch,
  rc5_cfg_if.sink  cfg
);
  localparam int KEY_LIMIT = (MAX_KEY_BYTES > 16) ? 16 : MAX_KEY_BYTES;

  logic [63:0] key_low, key_high, init_vector;
  logic [4:0]  key_length;
  logic [7:0]  rounds;
  logic        pad_enable;
  logic [4:0]  key_bytes;
  rc5_pkg::dp_cmd_t  cmd;
  rc5_pkg::dp_stat_t stat;
  logic [63:0] result;

  assign cfg.ready = 1'b1;

  // Configuration registers: user must write them only while the engine is idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= '0;
      key_high <= '0;
      key_length <= 5'd16;
      rounds <= 8'd12;
      pad_enable <= 1'b1;
      init_vector <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        rc5_pkg::REG_KEY_LOW:    key_low <= cfg.data;
        rc5_pkg::REG_KEY_HIGH:   key_high <= cfg.data;
        rc5_pkg::REG_KEY_LENGTH: key_length <= cfg.data[4:0];
        rc5_pkg::REG_ROUNDS:     rounds <= cfg.data[7:0];
        rc5_pkg::REG_PAD_ENABLE: pad_enable <= cfg.data[0];
        rc5_pkg::REG_INIT_VEC:   init_vector <= cfg.data;
        default: ;
      endcase
    end
  end

  // A zero key length counts as one byte; longer keys saturate at the limit.
  assign key_bytes = (key_length == 5'd0) ? 5'd1 :
                     (key_length > 5'(KEY_LIMIT)) ? 5'(KEY_LIMIT) : key_length;

  rc5_control #(.MAX_ROUNDS(MAX_ROUNDS)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_kind(in_ch.kind), .in_ready(in_ch.ready),
    .rounds(rounds), .pad_enable(pad_enable),
    .stat(stat), .result(result), .cmd(cmd),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .byte_out(out_ch.byte_out), .block_out(out_ch.block_out),
    .status(out_ch.status), .last(out_ch.last)
  );

  rc5_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .data_byte(in_ch.data_in), .block_in(in_ch.block_in),
    .key_low(key_low), .key_high(key_high), .key_bytes(key_bytes),
    .init_vector(init_vector), .stat(stat), .result(result)
  );
endmodule
`default_nettype wire
